// ===== rtl/gbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int unsigned CORNER_W = 13;
  localparam int unsigned AREA_W   = 25;
  localparam int unsigned ENTRY_W  = 4 * CORNER_W + AREA_W;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned PROD_W   = THR_W + AREA_W + 1;

  localparam logic [CORNER_W-1:0] SIDE_LIMIT = 13'd4096;
  localparam logic [THR_W-1:0]    THR_RESET  = 16'd32768;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } gbs_state_e;

endpackage : gbs_pkg
`default_nettype wire

// ===== rtl/greedy_box_suppression.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression of score-sorted pixel boxes against a
// memory of kept boxes.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. The
//   box is checked against every kept box of its set, one memory entry read
//   per cycle, through a three-stage compare pipeline (intersection product,
//   threshold product, compare).
//   The result strobe follows the end of the scan through the S_DONE state
//   and the result register; a new request is taken in the cycle the result
//   is shown, so the block finishes one item before it takes the next.
//   The result (keep_o, box_index_o, store_full_o) is shown for exactly one
//   cycle with result_valid_o high; the receiver cannot stall it.
//   first_in_set_i empties the kept store and restarts the box index.
//   The user is to write the threshold register over cfg_valid_i/cfg_ready_o
//   only while the block is idle; the block itself does not enforce this.
//   Reset empties the store, clears the index and loads the threshold with
//   one half; the memory contents are not cleared.
// ----------------------------------------------------------------------------
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int unsigned MAX_KEPT  = 64,
  parameter int unsigned MAX_BOXES = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [11:0]         box_left_i,
  input  wire logic [11:0]         box_top_i,
  input  wire logic [12:0]         box_width_i,
  input  wire logic [12:0]         box_height_i,
  input  wire logic                first_in_set_i,
  output      logic                result_valid_o,
  output      logic                keep_o,
  output      logic [INDEX_W-1:0]  box_index_o,
  output      logic                store_full_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [THR_W-1:0]    cfg_data_i
);

  localparam int unsigned AW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CW    = $clog2(MAX_KEPT + 1);
  localparam int unsigned POS_W = $clog2(MAX_BOXES);

  gbs_state_e            state_q, state_d;
  logic [CW-1:0]         k_q, k_d;
  logic [CW-1:0]         count_q, count_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [POS_W-1:0]      idx_q, idx_d;
  logic                  keep_q, keep_d;
  logic [THR_W-1:0]      thr_q;
  logic                  v1_q, v2_q, v3_q;
  logic                  res_valid_q, res_keep_q, res_full_q;
  logic [INDEX_W-1:0]    res_idx_q;

  logic                  accept;
  logic                  rd_en;
  logic                  wr_en;
  logic                  full_d;
  logic                  fail;

  logic [CORNER_W-1:0]   w_sat, h_sat;
  logic [2*CORNER_W-1:0] area_full;

  logic [CORNER_W-1:0]   box_l_q, box_t_q, box_r_q, box_b_q;
  logic [AREA_W-1:0]     area_q;

  logic [ENTRY_W-1:0]    mem_q [MAX_KEPT];
  logic [ENTRY_W-1:0]    rd_data_q;

  logic [CORNER_W-1:0]   kl, kt, kr, kb;
  logic [AREA_W-1:0]     karea;
  logic [CORNER_W-1:0]   x1, y1, x2, y2, dx, dy;
  logic [2*CORNER_W-1:0] inter_full;
  logic [AREA_W-1:0]     inter_d1;
  logic [AREA_W-1:0]     inter1_q, karea1_q;

  logic [AREA_W:0]       uni;
  logic [PROD_W-1:0]     prod_d;
  logic [PROD_W-1:0]     prod_q;
  logic [AREA_W-1:0]     inter2_q;
  logic                  half_d, half_q;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Input box: saturate sides, form corners and area
  assign w_sat     = (box_width_i > SIDE_LIMIT) ? SIDE_LIMIT : box_width_i;
  assign h_sat     = (box_height_i > SIDE_LIMIT) ? SIDE_LIMIT : box_height_i;
  assign area_full = {{CORNER_W{1'b0}}, w_sat} * {{CORNER_W{1'b0}}, h_sat};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      box_l_q <= {1'b0, box_left_i};
      box_t_q <= {1'b0, box_top_i};
      box_r_q <= {1'b0, box_left_i} + w_sat;
      box_b_q <= {1'b0, box_top_i} + h_sat;
      area_q  <= area_full[AREA_W-1:0];
    end
  end

  // Kept-box memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= {box_l_q, box_t_q, box_r_q, box_b_q, area_q};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[k_q[AW-1:0]];
    end
  end

  // Stage 1: intersection
  assign {kl, kt, kr, kb, karea} = rd_data_q;
  assign x1 = (box_l_q > kl) ? box_l_q : kl;
  assign y1 = (box_t_q > kt) ? box_t_q : kt;
  assign x2 = (box_r_q < kr) ? box_r_q : kr;
  assign y2 = (box_b_q < kb) ? box_b_q : kb;
  assign dx = x2 - x1;
  assign dy = y2 - y1;
  assign inter_full = {{CORNER_W{1'b0}}, dx} * {{CORNER_W{1'b0}}, dy};
  assign inter_d1   = ((x2 > x1) && (y2 > y1)) ? inter_full[AREA_W-1:0] : '0;

  // Stage 2: union, threshold product and half-area test
  assign uni    = {1'b0, area_q} + {1'b0, karea1_q} - {1'b0, inter1_q};
  assign prod_d = {{(PROD_W-THR_W){1'b0}}, thr_q} * {{(PROD_W-AREA_W-1){1'b0}}, uni};
  assign half_d = ({inter1_q, 1'b0} > {1'b0, karea1_q}) ||
                  ({inter1_q, 1'b0} > {1'b0, area_q});

  // Stage 3: compare
  assign fail = v3_q && (half_q || ({1'b0, inter2_q, {THR_W{1'b0}}} > prod_q));

  always_ff @(posedge clk_i) begin
    inter1_q <= inter_d1;
    karea1_q <= karea;
    inter2_q <= inter1_q;
    prod_q   <= prod_d;
    half_q   <= half_d;
  end

  // Control
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    count_d = count_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    keep_d  = keep_q;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    full_d  = 1'b0;
    busy    = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d   = first_in_set_i ? '0 : pos_q;
          pos_d   = (idx_d == POS_W'(MAX_BOXES - 1)) ? '0 : idx_d + 1'b1;
          count_d = first_in_set_i ? '0 : count_q;
          k_d     = '0;
          keep_d  = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (fail) begin
          keep_d = 1'b0;
        end
        if (k_q < count_q) begin
          rd_en = 1'b1;
          k_d   = k_q + 1'b1;
        end else if (!v1_q && !v2_q && !v3_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        wr_en   = keep_q && (count_q < CW'(MAX_KEPT));
        full_d  = keep_q && !wr_en;
        count_d = wr_en ? count_q + 1'b1 : count_q;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      keep_q      <= 1'b0;
      thr_q       <= THR_RESET;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      res_valid_q <= 1'b0;
      res_keep_q  <= 1'b0;
      res_full_q  <= 1'b0;
      res_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      keep_q      <= keep_d;
      v1_q        <= rd_en;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      res_valid_q <= (state_q == S_DONE);
      if (state_q == S_DONE) begin
        res_keep_q <= keep_q;
        res_full_q <= full_d;
        res_idx_q  <= INDEX_W'(idx_q);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign keep_o         = res_keep_q;
  assign box_index_o    = res_idx_q;
  assign store_full_o   = res_full_q;

`ifndef SYNTHESIS
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_DONE))
    else $error("result strobe without finished scan");

  a_full_implies_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && store_full_o |-> keep_o)
    else $error("store_full on a suppressed box");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEPT))
    else $error("kept count beyond store depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> k_q <= count_q)
    else $error("read index beyond kept count");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request taken but block not busy");
`endif

endmodule : greedy_box_suppression
`default_nettype wire

// ===== tb/gbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_checker
// Watches the request, result and threshold channels of the box suppression
// block, predicts keep, box index and store-full for every request, and
// compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module gbs_checker
  import gbs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_i,
  input  wire logic [11:0]        box_left_i,
  input  wire logic [11:0]        box_top_i,
  input  wire logic [12:0]        box_width_i,
  input  wire logic [12:0]        box_height_i,
  input  wire logic               first_in_set_i,
  input  wire logic               result_valid_i,
  input  wire logic               keep_i,
  input  wire logic [INDEX_W-1:0] box_index_i,
  input  wire logic               store_full_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [THR_W-1:0]   cfg_data_i,
  output int                      pending_o,
  output int                      failures_o
);

  localparam int KEPT_DEPTH = 64;

  typedef struct packed {
    logic               keep;
    logic [INDEX_W-1:0] index;
    logic               full;
  } box_verdict_t;

  logic [CORNER_W-1:0] kept_left   [KEPT_DEPTH];
  logic [CORNER_W-1:0] kept_top    [KEPT_DEPTH];
  logic [CORNER_W-1:0] kept_right  [KEPT_DEPTH];
  logic [CORNER_W-1:0] kept_bottom [KEPT_DEPTH];
  logic [AREA_W-1:0]   kept_area   [KEPT_DEPTH];
  logic [6:0]          kept_count;
  logic [INDEX_W-1:0]  set_pos;
  logic [THR_W-1:0]    threshold;
  box_verdict_t        expected_verdicts[$];
  int                  mismatches = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t gbs_checker %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic box_verdict_t suppress_box(
    input logic [11:0] left,
    input logic [11:0] top,
    input logic [12:0] width,
    input logic [12:0] height,
    input logic        first
  );
    logic [CORNER_W-1:0] w, h, l, t, r, b, x1, y1, x2, y2;
    logic [63:0]         area, inter, uni;
    box_verdict_t        v;
    w = (width > SIDE_LIMIT) ? SIDE_LIMIT : width;
    h = (height > SIDE_LIMIT) ? SIDE_LIMIT : height;
    l = {1'b0, left};
    t = {1'b0, top};
    r = l + w;
    b = t + h;
    area = 64'(w) * 64'(h);
    if (first) begin
      kept_count = '0;
      set_pos = '0;
    end
    v.keep = 1'b1;
    v.full = 1'b0;
    v.index = set_pos;
    for (int k = 0; k < kept_count; k++) begin
      x1 = (l > kept_left[k]) ? l : kept_left[k];
      y1 = (t > kept_top[k]) ? t : kept_top[k];
      x2 = (r < kept_right[k]) ? r : kept_right[k];
      y2 = (b < kept_bottom[k]) ? b : kept_bottom[k];
      inter = '0;
      if (x2 > x1 && y2 > y1) inter = 64'(x2 - x1) * 64'(y2 - y1);
      uni = area + 64'(kept_area[k]) - inter;
      if ((inter << 16) > 64'(threshold) * uni || 2 * inter > 64'(kept_area[k]) ||
          2 * inter > area)
        v.keep = 1'b0;
    end
    if (v.keep) begin
      if (kept_count < KEPT_DEPTH) begin
        kept_left[kept_count]   = l;
        kept_top[kept_count]    = t;
        kept_right[kept_count]  = r;
        kept_bottom[kept_count] = b;
        kept_area[kept_count]   = area[AREA_W-1:0];
        kept_count++;
      end else begin
        v.full = 1'b1;
      end
    end
    set_pos++;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    box_verdict_t want;
    box_verdict_t fresh;
    if (!rst_ni) begin
      kept_count = '0;
      set_pos = '0;
      threshold = THR_RESET;
      expected_verdicts.delete();
      pending_o <= 0;
      failures_o <= mismatches;
    end else begin
      if (result_valid_i) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result with no request waiting", box_index_i, -1);
        end else begin
          want = expected_verdicts.pop_front();
          if (keep_i !== want.keep) report_mismatch("keep", keep_i, want.keep);
          if (box_index_i !== want.index)
            report_mismatch("box_index", box_index_i, want.index);
          if (store_full_i !== want.full)
            report_mismatch("store_full", store_full_i, want.full);
        end
      end
      if (cfg_valid_i && cfg_ready_i) threshold = cfg_data_i;
      if (start_i && !busy_i) begin
        fresh = suppress_box(box_left_i, box_top_i, box_width_i,
                             box_height_i, first_in_set_i);
        expected_verdicts.insert(expected_verdicts.size(), fresh);
      end
      pending_o <= expected_verdicts.size();
      failures_o <= mismatches;
    end
  end

endmodule : gbs_checker

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives score-sorted boxes and threshold writes into the greedy box
// suppression block: directed corner cases, a long set under a full-frame
// box, then random clustered, disjoint-grid and noise sets under several
// sender idle patterns. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import gbs_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int PHASE_BOXES = 320;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [11:0]        box_left_i;
  logic [11:0]        box_top_i;
  logic [12:0]        box_width_i;
  logic [12:0]        box_height_i;
  logic               first_in_set_i;
  logic               result_valid_o;
  logic               keep_o;
  logic [INDEX_W-1:0] box_index_o;
  logic               store_full_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [THR_W-1:0]   cfg_data_i;
  int                 pending;
  int                 failures;
  int                 idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  greedy_box_suppression u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .box_left_i     (box_left_i),
    .box_top_i      (box_top_i),
    .box_width_i    (box_width_i),
    .box_height_i   (box_height_i),
    .first_in_set_i (first_in_set_i),
    .result_valid_o (result_valid_o),
    .keep_o         (keep_o),
    .box_index_o    (box_index_o),
    .store_full_o   (store_full_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  gbs_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .box_left_i     (box_left_i),
    .box_top_i      (box_top_i),
    .box_width_i    (box_width_i),
    .box_height_i   (box_height_i),
    .first_in_set_i (first_in_set_i),
    .result_valid_i (result_valid_o),
    .keep_i         (keep_o),
    .box_index_i    (box_index_o),
    .store_full_i   (store_full_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending),
    .failures_o     (failures)
  );

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("greedy_box_suppression: mismatch");
    $finish;
  end

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic push_box(input int l, input int t, input int w, input int h, input bit first);
    start <= 1'b1;
    box_left_i <= 12'(l);
    box_top_i <= 12'(t);
    box_width_i <= 13'(w);
    box_height_i <= 13'(h);
    first_in_set_i <= first;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if ($urandom_range(0, 149) == 0) begin
      drain();
    end else if (int'($urandom_range(0, 99)) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
    end
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  initial begin
    int sent, n, cx, cy, bw, bh, offx, offy, row0, l, t, w, h;
    logic [THR_W-1:0] phase_thr [4];
    rst_ni = 1'b0;
    start = 1'b0;
    box_left_i = '0;
    box_top_i = '0;
    box_width_i = '0;
    box_height_i = '0;
    first_in_set_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_box(0, 0, 0, 0, 1);
    push_box(0, 0, 4096, 4096, 0);
    push_box(0, 0, 4096, 4096, 0);
    push_box(4095, 4095, 4096, 4096, 0);
    push_box(4095, 4095, 8191, 8191, 0);
    push_box(100, 100, 0, 50, 0);
    push_box(4095, 0, 4096, 0, 0);
    push_box(0, 0, 100, 100, 1);
    push_box(50, 0, 100, 100, 0);
    push_box(0, 0, 200, 100, 0);
    push_box(10, 10, 20, 20, 0);
    push_box(150, 0, 100, 100, 0);
    write_threshold(16'd16384);
    push_box(0, 0, 100, 100, 1);
    push_box(60, 0, 100, 100, 0);
    push_box(59, 0, 100, 100, 0);
    write_threshold(16'd0);
    push_box(0, 0, 10, 10, 1);
    push_box(9, 9, 10, 10, 0);
    write_threshold(16'd65535);
    push_box(0, 0, 10, 10, 1);
    push_box(5, 0, 10, 10, 0);

    // one long set under a full-frame box
    push_box(0, 0, 4096, 4096, 1);
    for (int i = 0; i < 300; i++) begin
      l = $urandom_range(0, 1000);
      t = $urandom_range(0, 1000);
      push_box(l, t, $urandom_range(2048, 4096 - l), $urandom_range(2048, 4096 - t), 0);
    end

    phase_thr[0] = 16'd32768;
    phase_thr[1] = 16'd65535;
    phase_thr[2] = 16'd0;
    phase_thr[3] = 16'($urandom_range(0, 65535));
    for (int phase = 0; phase < 4; phase++) begin
      write_threshold(phase_thr[phase]);
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 0;
        default: idle_pct = 11;
      endcase
      sent = 0;
      while (sent < PHASE_BOXES) begin
        case ($urandom_range(0, 99)) inside
          [0:69]: begin
            n = $urandom_range(1, 24);
            cx = $urandom_range(0, 4095);
            cy = $urandom_range(0, 4095);
            bw = $urandom_range(1, 700);
            bh = $urandom_range(1, 700);
            for (int j = 0; j < n; j++) begin
              if ($urandom_range(0, 9) == 0) begin
                cx = $urandom_range(0, 4095);
                cy = $urandom_range(0, 4095);
              end
              l = clip(cx + int'($urandom_range(0, bw)) - bw / 2, 0, 4095);
              t = clip(cy + int'($urandom_range(0, bh)) - bh / 2, 0, 4095);
              w = clip(bw + int'($urandom_range(0, bw / 2)) - bw / 4, 1, 4096);
              h = clip(bh + int'($urandom_range(0, bh / 2)) - bh / 4, 1, 4096);
              if ($urandom_range(0, 11) == 0) w = 0;
              if ($urandom_range(0, 11) == 0) h = 0;
              push_box(l, t, w, h, j == 0);
            end
          end
          [70:81]: begin
            n = $urandom_range(66, 75);
            row0 = $urandom_range(0, 60);
            for (int j = 0; j < n; j++) begin
              offx = $urandom_range(0, 63);
              offy = $urandom_range(0, 63);
              push_box((j % 64) * 64 + offx, (row0 + j / 64) * 64 + offy,
                       $urandom_range(0, 64 - offx), $urandom_range(0, 64 - offy), j == 0);
            end
          end
          default: begin
            n = $urandom_range(1, 6);
            for (int j = 0; j < n; j++)
              push_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(0, 3) == 0);
          end
        endcase
        sent += n;
      end
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (failures == 0) begin
      $display("greedy_box_suppression: match");
    end else begin
      $display("greedy_box_suppression: mismatch");
    end
    $finish;
  end

endmodule : testbench
